/* rtl/core/tltr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tltr_pkg
// Shared sizes, codes, payload types and color decode for the tile renderer.
// ----------------------------------------------------------------------------
package tltr_pkg;

    // Store sizes (powers of two)
    localparam int TILE_STORE_DEPTH = 8192;
    localparam int TILE_AW          = $clog2(TILE_STORE_DEPTH);
    localparam int GRAPHICS_DEPTH   = 1048576;
    localparam int GFX_AW           = $clog2(GRAPHICS_DEPTH);
    localparam int PALETTE_DEPTH    = 512;
    localparam int PAL_AW           = $clog2(PALETTE_DEPTH);

    // Tile addressing
    localparam int TILE_BANK_OFFSET = 'h1000;
    localparam int FG_OFFSET        = 'h800;
    localparam int TILE_CODE_BITS   = 14;
    localparam int GFX_FULL_BITS    = TILE_CODE_BITS + 6;

    // Item kinds
    localparam logic [2:0] KIND_TILE_LOW = 3'd0;
    localparam logic [2:0] KIND_ATTR     = 3'd1;
    localparam logic [2:0] KIND_BANK     = 3'd2;
    localparam logic [2:0] KIND_GFX      = 3'd3;
    localparam logic [2:0] KIND_PROM     = 3'd4;
    localparam logic [2:0] KIND_RENDER   = 3'd5;

    // Bank control bit that selects the upper tile bank
    localparam int BANK_SEL_BIT = 1;

    // Foreground pixel value that lets the background through
    localparam logic [7:0] FG_SEE_THROUGH = 8'd1;

    typedef struct packed {
        logic [2:0]  kind;
        logic [19:0] address;
        logic [7:0]  data;
        logic [2:0]  row_in_cell;
        logic [8:0]  line;
        logic [6:0]  column;
        logic        end_of_row;
    } item_t;

    typedef struct packed {
        logic [8:0] line_out;
        logic [9:0] pixel_x;
        logic [8:0] color_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       last_of_cell;
        logic       row_done;
    } pixel_t;

    // Three-bit intensity ramp, fits in eight bits
    function automatic logic [7:0] ramp3(input logic b0, input logic b1, input logic b2);
        logic [9:0] sum;
        sum = (b0 ? 10'h021 : 10'h000) + (b1 ? 10'h047 : 10'h000)
            + (b2 ? 10'h097 : 10'h000);
        return sum[7:0];
    endfunction

    function automatic logic [7:0] ramp2(input logic b0, input logic b1);
        return (b0 ? 8'h55 : 8'h00) + (b1 ? 8'haa : 8'h00);
    endfunction

endpackage

/* rtl/core/two_layer_tile_row_renderer_top.sv */
`timescale 1ns / 1ps
// Writes, loads and bank sets give no pixels.
// A render item gives eight pixels, one per cycle while the output is not stalled;
// the first pixel follows the item transfer through the tile read, the graphics
// read, the palette read and the output register. No new item is taken until the
// tile fetch, the eight graphics reads and the palette read pipeline have drained.
// Reset clears the bank register and control; stores need no clearing pass.
// ----------------------------------------------------------------------------
// two_layer_tile_row_renderer_top
// Two-layer character-cell renderer: tile, attribute, graphics and palette
// stores with a pixel pipeline that reads graphics and palette memories.
// ----------------------------------------------------------------------------
module two_layer_tile_row_renderer_top
    import tltr_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   item_valid,
    output logic   item_stall,
    input  item_t  item,
    output logic   pixel_valid,
    input  logic   pixel_stall,
    output pixel_t pixel
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_TILE  = 3'b010,
        ST_FETCH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic item_fire;
    logic advance;

    logic [7:0]         bank_reg;
    logic [TILE_AW-1:0] bank_add;
    logic [TILE_AW-1:0] tile_bg_addr;
    logic [TILE_AW-1:0] tile_fg_addr;

    logic tile_we, attr_we, gfx_we, prom_we, tile_re;

    logic [7:0] tile_bg_data, tile_fg_data, attr_bg_data, attr_fg_data;
    logic [7:0] gfx_bg_data, gfx_fg_data, prom_data;

    // Per-item fields held for the pixel run
    logic [2:0] row_reg;
    logic [8:0] line_reg;
    logic [6:0] column_reg;
    logic       eor_reg;
    logic [TILE_CODE_BITS-1:0] bg_tile_reg, fg_tile_reg;
    logic       bg_pal_reg, fg_pal_reg;

    logic [2:0] px_reg, px_next;

    logic [GFX_FULL_BITS-1:0] gfx_bg_full, gfx_fg_full;
    logic [GFX_AW-1:0]        gfx_rd_bg, gfx_rd_fg;
    logic                     gfx_re;

    logic       s1_v_reg, s2_v_reg;
    logic [2:0] s1_px_reg, s2_px_reg;
    logic [8:0] s1_idx;
    logic [8:0] s2_idx_reg;
    logic       prom_re;

    logic   pixel_valid_reg;
    pixel_t pixel_reg, pixel_next;

    assign item_fire = item_valid && !item_stall;
    assign advance   = !pixel_valid_reg || !pixel_stall;

    // Hold new items until the pipeline has drained
    assign item_stall = (state_reg != ST_IDLE) || s1_v_reg || s2_v_reg;

    assign bank_add     = bank_reg[BANK_SEL_BIT] ? TILE_AW'(TILE_BANK_OFFSET) : '0;
    assign tile_bg_addr = item.address[TILE_AW-1:0] + bank_add;
    assign tile_fg_addr = tile_bg_addr + TILE_AW'(FG_OFFSET);

    assign tile_we = item_fire && (item.kind == KIND_TILE_LOW);
    assign attr_we = item_fire && (item.kind == KIND_ATTR);
    assign gfx_we  = item_fire && (item.kind == KIND_GFX);
    assign prom_we = item_fire && (item.kind == KIND_PROM);
    assign tile_re = item_fire && (item.kind == KIND_RENDER);

    tltr_ram #(.WIDTH(8), .DEPTH(TILE_STORE_DEPTH)) u_tile_ram (
        .clk       (clk),
        .wr_en     (tile_we),
        .wr_addr   (tile_bg_addr),
        .wr_data   (item.data),
        .rd_en_a   (tile_re),
        .rd_addr_a (tile_bg_addr),
        .rd_data_a (tile_bg_data),
        .rd_en_b   (tile_re),
        .rd_addr_b (tile_fg_addr),
        .rd_data_b (tile_fg_data)
    );

    tltr_ram #(.WIDTH(8), .DEPTH(TILE_STORE_DEPTH)) u_attr_ram (
        .clk       (clk),
        .wr_en     (attr_we),
        .wr_addr   (tile_bg_addr),
        .wr_data   (item.data),
        .rd_en_a   (tile_re),
        .rd_addr_a (tile_bg_addr),
        .rd_data_a (attr_bg_data),
        .rd_en_b   (tile_re),
        .rd_addr_b (tile_fg_addr),
        .rd_data_b (attr_fg_data)
    );

    // Graphics addresses: tile * 64 + row * 8 + pixel, wrapped to the store
    assign gfx_bg_full = {bg_tile_reg, row_reg, px_reg};
    assign gfx_fg_full = {fg_tile_reg, row_reg, px_reg};
    assign gfx_rd_bg   = gfx_bg_full[GFX_AW-1:0];
    assign gfx_rd_fg   = gfx_fg_full[GFX_AW-1:0];
    assign gfx_re      = (state_reg == ST_FETCH) && advance;

    tltr_ram #(.WIDTH(8), .DEPTH(GRAPHICS_DEPTH)) u_gfx_ram (
        .clk       (clk),
        .wr_en     (gfx_we),
        .wr_addr   (item.address[GFX_AW-1:0]),
        .wr_data   (item.data),
        .rd_en_a   (gfx_re),
        .rd_addr_a (gfx_rd_bg),
        .rd_data_a (gfx_bg_data),
        .rd_en_b   (gfx_re),
        .rd_addr_b (gfx_rd_fg),
        .rd_data_b (gfx_fg_data)
    );

    // Background shows through where the foreground pixel is the see-through value
    assign s1_idx  = (gfx_fg_data == FG_SEE_THROUGH) ? {bg_pal_reg, gfx_bg_data}
                                                     : {fg_pal_reg, gfx_fg_data};
    assign prom_re = s1_v_reg && advance;

    tltr_ram #(.WIDTH(8), .DEPTH(PALETTE_DEPTH)) u_prom_ram (
        .clk       (clk),
        .wr_en     (prom_we),
        .wr_addr   (item.address[PAL_AW-1:0]),
        .wr_data   (item.data),
        .rd_en_a   (prom_re),
        .rd_addr_a (s1_idx[PAL_AW-1:0]),
        .rd_data_a (prom_data),
        .rd_en_b   (1'b0),
        .rd_addr_b ('0),
        .rd_data_b ()
    );

    always_comb
    begin
        state_next = state_reg;
        px_next    = px_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (tile_re)
                begin
                    state_next = ST_TILE;
                end
            end
            ST_TILE:
            begin
                state_next = ST_FETCH;
                px_next    = '0;
            end
            ST_FETCH:
            begin
                if (advance)
                begin
                    px_next = px_reg + 3'd1;
                    if (px_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pixel_next              = pixel_reg;
        pixel_next.line_out     = line_reg;
        pixel_next.pixel_x      = {column_reg, s2_px_reg};
        pixel_next.color_index  = s2_idx_reg;
        pixel_next.red          = ramp3(prom_data[5], prom_data[6], prom_data[7]);
        pixel_next.green        = ramp3(prom_data[2], prom_data[3], prom_data[4]);
        pixel_next.blue         = ramp2(prom_data[0], prom_data[1]);
        pixel_next.last_of_cell = (s2_px_reg == 3'd7);
        pixel_next.row_done     = (s2_px_reg == 3'd7) && eor_reg;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            bank_reg        <= '0;
            px_reg          <= '0;
            s1_v_reg        <= 1'b0;
            s2_v_reg        <= 1'b0;
            pixel_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            px_reg    <= px_next;
            if (item_fire && (item.kind == KIND_BANK))
            begin
                bank_reg <= item.data;
            end
            if (advance)
            begin
                s1_v_reg        <= (state_reg == ST_FETCH);
                s2_v_reg        <= s1_v_reg;
                pixel_valid_reg <= s2_v_reg;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (tile_re)
        begin
            row_reg    <= item.row_in_cell;
            line_reg   <= item.line;
            column_reg <= item.column;
            eor_reg    <= item.end_of_row;
        end
        if (state_reg == ST_TILE)
        begin
            bg_tile_reg <= {attr_bg_data[5:0], tile_bg_data};
            fg_tile_reg <= {attr_fg_data[5:0], tile_fg_data};
            bg_pal_reg  <= attr_bg_data[7];
            fg_pal_reg  <= attr_fg_data[7];
        end
        if (advance)
        begin
            s1_px_reg  <= px_reg;
            s2_px_reg  <= s1_px_reg;
            s2_idx_reg <= s1_idx;
            if (s2_v_reg)
            begin
                pixel_reg <= pixel_next;
            end
        end
    end

    assign pixel_valid = pixel_valid_reg;
    assign pixel       = pixel_reg;

`ifndef ASSERT_OFF
    a_last_matches_x: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid |-> (pixel.last_of_cell == (pixel.pixel_x[2:0] == 3'd7)))
        else $error("last_of_cell does not match pixel position");

    a_row_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_valid && pixel.row_done) |-> pixel.last_of_cell)
        else $error("row_done without last_of_cell");

    a_render_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tile_re |=> (state_reg == ST_TILE))
        else $error("render transfer did not start tile fetch");

    a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_fire |-> (!s1_v_reg && !s2_v_reg && (state_reg == ST_IDLE)))
        else $error("item taken while pixel pipeline busy");
`endif

endmodule

/* rtl/core/tltr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tltr_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tltr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en_a,
    input  logic [AW-1:0]    rd_addr_a,
    output logic [WIDTH-1:0] rd_data_a,
    input  logic             rd_en_b,
    input  logic [AW-1:0]    rd_addr_b,
    output logic [WIDTH-1:0] rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds while the port is not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en_a)
        begin
            rd_data_a <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule
